[rtl/assert_macros.svh]
// assertion macros used by the rtl top, polygon_segment_cut_test
// each macro expands to a labeled concurrent assertion, or to nothing with ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/psct_pkg.sv]
// types and constants for the polygon segment cut test
// no dependencies
package psct_pkg;

  // two segment tests per vertex: the new edge and the closing edge
  localparam int TESTS          = 2;
  localparam int PTS_PER_TEST   = 4;
  localparam int TURNS_PER_TEST = 4;
  localparam int NUM_TURNS      = TESTS * TURNS_PER_TEST;

  typedef enum logic [1:0] {
    ORI_COLLINEAR,
    ORI_POS,
    ORI_NEG
  } orient_t;

  typedef struct packed {
    logic test_edge;  // a previous vertex exists, so the new edge is tested
    logic last;       // closing edge tested and result emitted
  } item_ctl_t;

endpackage

[rtl/polygon_segment_cut_test.sv]
// polygon segment cut test: input register, edge tests, result register
// depends on psct_pkg and assert_macros.svh
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | segment endpoints, vertex, last_vertex
//   out     | output    | out_valid / out_stall| cut
//
// one vertex word per cycle while the result side is free
// out_valid rises when the last vertex of a polygon moves from the input register to the result register
// between the two registers: sixteen parallel multipliers, product compares and combine
// rst_n is synchronous: it clears the valid bits, run and hit flags and stored vertices
// a held result stalls only a last vertex word in the input register; other words pass
`include "assert_macros.svh"

module polygon_segment_cut_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_cut
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NT = psct_pkg::NUM_TURNS;
  localparam int TT = psct_pkg::TURNS_PER_TEST;

  // run state
  logic signed [W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                in_run_r;
  logic signed [W-1:0] first_x_nxt, first_y_nxt;
  logic                in_run_nxt;

  // input register
  logic                s1_v_r;
  psct_pkg::item_ctl_t s1_ctl_r;
  logic signed [W-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  logic signed [W-1:0] s1_vx_r, s1_vy_r, s1_px_r, s1_py_r, s1_fx_r, s1_fy_r;

  // products and bounding box flags
  logic signed [PW-1:0] m1_b [NT];
  logic signed [PW-1:0] m2_b [NT];
  logic                 on_b [NT];

  // result register and sticky hit
  logic out_v_r, out_cut_r, hit_r;
  logic hit_nxt;

  logic in_acc, out_free, c_go, s1_free;

  logic signed [W-1:0] pt_x [psct_pkg::TESTS][psct_pkg::PTS_PER_TEST];
  logic signed [W-1:0] pt_y [psct_pkg::TESTS][psct_pkg::PTS_PER_TEST];

  psct_pkg::orient_t ori [NT];
  logic [psct_pkg::TESTS-1:0] cut_c;
  logic                       base_hit, item_hit;

  // ---------------- flow control ----------------
  assign out_free = !out_v_r || !out_stall;
  assign c_go     = s1_v_r && (!s1_ctl_r.last || out_free);
  assign s1_free  = !s1_v_r || c_go;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  // ---------------- input register ----------------
  always_comb begin
    first_x_nxt = in_run_r ? first_x_r : in_vertex_x;
    first_y_nxt = in_run_r ? first_y_r : in_vertex_y;
    in_run_nxt  = !in_last_vertex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r  <= 1'b0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        in_run_r  <= in_run_nxt;
        first_x_r <= first_x_nxt;
        first_y_r <= first_y_nxt;
        prev_x_r  <= in_vertex_x;
        prev_y_r  <= in_vertex_y;
        s1_v_r    <= 1'b1;
      end else if (c_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r.test_edge <= in_run_r;
      s1_ctl_r.last      <= in_last_vertex;
      s1_sx_r <= in_seg_start_x;
      s1_sy_r <= in_seg_start_y;
      s1_ex_r <= in_seg_end_x;
      s1_ey_r <= in_seg_end_y;
      s1_vx_r <= in_vertex_x;
      s1_vy_r <= in_vertex_y;
      s1_px_r <= prev_x_r;
      s1_py_r <= prev_y_r;
      s1_fx_r <= first_x_nxt;
      s1_fy_r <= first_y_nxt;
    end
  end

  // ---------------- multipliers ----------------
  // points per test: segment start, segment end, edge start, edge end
  always_comb begin
    pt_x[0][0] = s1_sx_r;  pt_y[0][0] = s1_sy_r;
    pt_x[0][1] = s1_ex_r;  pt_y[0][1] = s1_ey_r;
    pt_x[0][2] = s1_px_r;  pt_y[0][2] = s1_py_r;
    pt_x[0][3] = s1_vx_r;  pt_y[0][3] = s1_vy_r;
    pt_x[1][0] = s1_sx_r;  pt_y[1][0] = s1_sy_r;
    pt_x[1][1] = s1_ex_r;  pt_y[1][1] = s1_ey_r;
    pt_x[1][2] = s1_vx_r;  pt_y[1][2] = s1_vy_r;
    pt_x[1][3] = s1_fx_r;  pt_y[1][3] = s1_fy_r;
  end

  for (genvar k = 0; k < NT; k++) begin : g_turn
    localparam int T  = k / TT;
    localparam int J  = k % TT;
    // turn(p, q, r) with r tested against the box of p and q
    localparam int PI = (J < 2) ? 0 : 2;
    localparam int QI = (J < 2) ? 1 : 3;
    localparam int RI = (J == 0) ? 2 : (J == 1) ? 3 : (J == 2) ? 0 : 1;

    logic signed [DW-1:0] dqy, drx, dqx, dry;
    logic signed [W-1:0]  lox, hix, loy, hiy;

    assign dqy = DW'(pt_y[T][QI]) - DW'(pt_y[T][PI]);
    assign drx = DW'(pt_x[T][RI]) - DW'(pt_x[T][QI]);
    assign dqx = DW'(pt_x[T][QI]) - DW'(pt_x[T][PI]);
    assign dry = DW'(pt_y[T][RI]) - DW'(pt_y[T][QI]);

    assign m1_b[k] = PW'(dqy) * PW'(drx);
    assign m2_b[k] = PW'(dqx) * PW'(dry);

    assign lox = (pt_x[T][PI] < pt_x[T][QI]) ? pt_x[T][PI] : pt_x[T][QI];
    assign hix = (pt_x[T][PI] < pt_x[T][QI]) ? pt_x[T][QI] : pt_x[T][PI];
    assign loy = (pt_y[T][PI] < pt_y[T][QI]) ? pt_y[T][PI] : pt_y[T][QI];
    assign hiy = (pt_y[T][PI] < pt_y[T][QI]) ? pt_y[T][QI] : pt_y[T][PI];

    assign on_b[k] = (pt_x[T][RI] >= lox) && (pt_x[T][RI] <= hix) &&
                     (pt_y[T][RI] >= loy) && (pt_y[T][RI] <= hiy);
  end

  // ---------------- orientation and combine ----------------
  // sign of m1 - m2 read straight from the compare
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      if (m1_b[k] == m2_b[k]) begin
        ori[k] = psct_pkg::ORI_COLLINEAR;
      end else if (m1_b[k] > m2_b[k]) begin
        ori[k] = psct_pkg::ORI_POS;
      end else begin
        ori[k] = psct_pkg::ORI_NEG;
      end
    end
    for (int t = 0; t < psct_pkg::TESTS; t++) begin
      cut_c[t] = ((ori[t*TT] != ori[t*TT+1]) && (ori[t*TT+2] != ori[t*TT+3])) ||
                 ((ori[t*TT]   == psct_pkg::ORI_COLLINEAR) && on_b[t*TT])   ||
                 ((ori[t*TT+1] == psct_pkg::ORI_COLLINEAR) && on_b[t*TT+1]) ||
                 ((ori[t*TT+2] == psct_pkg::ORI_COLLINEAR) && on_b[t*TT+2]) ||
                 ((ori[t*TT+3] == psct_pkg::ORI_COLLINEAR) && on_b[t*TT+3]);
    end
    // first vertex of a run starts with a clear hit and tests no new edge
    base_hit = s1_ctl_r.test_edge && (hit_r || cut_c[0]);
    item_hit = base_hit || (s1_ctl_r.last && cut_c[1]);
    hit_nxt  = s1_ctl_r.last ? 1'b0 : base_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (c_go) begin
        hit_r <= hit_nxt;
      end
      if (c_go && s1_ctl_r.last) begin
        out_v_r <= 1'b1;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_go && s1_ctl_r.last) begin
      out_cut_r <= item_hit;
    end
  end

  assign out_valid = out_v_r;
  assign out_cut   = out_cut_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_no_load_when_held, clk, rst_n, out_v_r && out_stall, !(c_go && s1_ctl_r.last))
  `ASSERT_NEXT(a_run_ends_on_last, clk, rst_n, in_acc && in_last_vertex, !in_run_r)
  `ASSERT_NEXT(a_hit_clear_after_result, clk, rst_n, c_go && s1_ctl_r.last, !hit_r)
  `ASSERT_IMPL(a_s1_held_when_blocked, clk, rst_n, s1_v_r && !c_go, in_stall)

endmodule

[verif/tb_polygon_segment_cut_test.sv]
// self-checking testbench for polygon_segment_cut_test
// needs psct_pkg and the rtl top; directed vertex table, then random polygons
`timescale 1ns / 100ps

module tb_polygon_segment_cut_test;

  localparam int CW = 16;
  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, vx, vy;
    bit last;
    bit typed;  // cut below is written by hand
    bit cut;
  } vertex_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_seg_start_x = '0;
  logic signed [CW-1:0] in_seg_start_y = '0;
  logic signed [CW-1:0] in_seg_end_x = '0;
  logic signed [CW-1:0] in_seg_end_y = '0;
  logic signed [CW-1:0] in_vertex_x = '0;
  logic signed [CW-1:0] in_vertex_y = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_cut;

  // predictor state
  logic signed [CW-1:0] first_x, first_y, prev_x, prev_y;
  bit hit_seen, in_run;

  bit cut_expected[$];
  vertex_word_t directed_rows[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cuts_seen = 0;
  int cycles = 0;
  int stall_left = 0;

  polygon_segment_cut_test #(.COORD_WIDTH(CW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cut        (out_cut)
  );

  always #5 clk = ~clk;

  function automatic psct_pkg::orient_t turn_of(longint px, longint py, longint qx,
                                                longint qy, longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return psct_pkg::ORI_COLLINEAR;
    if (v > 0) return psct_pkg::ORI_POS;
    return psct_pkg::ORI_NEG;
  endfunction

  // q inside the bounding box of p and r
  function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    longint lox, hix, loy, hiy;
    lox = (px < rx) ? px : rx;
    hix = (px < rx) ? rx : px;
    loy = (py < ry) ? py : ry;
    hiy = (py < ry) ? ry : py;
    return qx >= lox && qx <= hix && qy >= loy && qy <= hiy;
  endfunction

  function automatic bit segments_cut(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
    psct_pkg::orient_t o1, o2, o3, o4;
    o1 = turn_of(ax, ay, bx, by, cx, cy);
    o2 = turn_of(ax, ay, bx, by, dx, dy);
    o3 = turn_of(cx, cy, dx, dy, ax, ay);
    o4 = turn_of(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == psct_pkg::ORI_COLLINEAR && in_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (o2 == psct_pkg::ORI_COLLINEAR && in_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (o3 == psct_pkg::ORI_COLLINEAR && in_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (o4 == psct_pkg::ORI_COLLINEAR && in_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // advance the polygon state by one accepted word
  function automatic void polygon_step(input vertex_word_t w, output bit produced,
                                       output bit cut);
    produced = 1'b0;
    cut = 1'b0;
    if (!in_run) begin
      first_x = w.vx;
      first_y = w.vy;
      hit_seen = 1'b0;
      in_run = 1'b1;
    end else if (segments_cut(w.sx, w.sy, w.ex, w.ey, prev_x, prev_y, w.vx, w.vy)) begin
      hit_seen = 1'b1;
    end
    prev_x = w.vx;
    prev_y = w.vy;
    if (w.last) begin
      // closing edge back to the first vertex
      if (segments_cut(w.sx, w.sy, w.ex, w.ey, w.vx, w.vy, first_x, first_y))
        hit_seen = 1'b1;
      produced = 1'b1;
      cut = hit_seen;
      hit_seen = 1'b0;
      in_run = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int scale);
    case (scale)
      0: return CW'(int'($urandom_range(0, 16)) - 8);
      1: return CW'(int'($urandom_range(0, 400)) - 200);
      2: return CW'($urandom);
      default: begin
        if ($urandom_range(0, 1))
          return CW'(32767 - int'($urandom_range(0, 3)));
        return CW'(-32768 + int'($urandom_range(0, 3)));
      end
    endcase
  endfunction

  function automatic void add_row(int sx, int sy, int ex, int ey, int vx, int vy, bit last,
                                  bit typed = 1'b0, bit cut = 1'b0);
    vertex_word_t w;
    w.sx = CW'(sx); w.sy = CW'(sy); w.ex = CW'(ex); w.ey = CW'(ey);
    w.vx = CW'(vx); w.vy = CW'(vy);
    w.last = last;
    w.typed = typed;
    w.cut = cut;
    directed_rows.push_back(w);
  endfunction

  task automatic send_word(input vertex_word_t w);
    int gap;
    bit produced, cut;
    // every fourth block of 64 words goes without source gaps
    gap = ((words_sent / 64) % 4 == 1) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seg_start_x <= w.sx;
    in_seg_start_y <= w.sy;
    in_seg_end_x <= w.ex;
    in_seg_end_y <= w.ey;
    in_vertex_x <= w.vx;
    in_vertex_y <= w.vy;
    in_last_vertex <= w.last;
    do @(posedge clk); while (in_stall);
    polygon_step(w, produced, cut);
    if (produced) cut_expected.push_back(w.typed ? w.cut : cut);
    words_sent++;
  endtask

  // result side stall, with quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ((cycles / 256) % 4 != 3 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_cut === 1'b1) cuts_seen++;
      if (cut_expected.size() == 0) begin
        $error("cut: no result expected, got %0b", out_cut);
        errors++;
      end else begin
        bit exp_cut;
        exp_cut = cut_expected.pop_front();
        if (out_cut !== exp_cut) begin
          $error("cut: expected %0b, got %0b", exp_cut, out_cut);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    vertex_word_t w;
    int scale, n, random_sent;
    random_sent = 0;

    // single vertex polygons against a horizontal segment
    add_row(-10, 0, 10, 0, 0, 0, 1, 1, 1);
    add_row(-10, 0, 10, 0, 0, 5, 1, 1, 0);
    add_row(-10, 0, 10, 0, 10, 0, 1, 1, 1);
    // point query
    add_row(3, 3, 3, 3, 3, 3, 1, 1, 1);
    add_row(3, 3, 3, 3, 4, 3, 1, 1, 0);
    // triangle crossing, then triangle clear
    add_row(-10, 0, 10, 0, 0, -5, 0);
    add_row(-10, 0, 10, 0, 5, 5, 0);
    add_row(-10, 0, 10, 0, -5, 5, 1);
    add_row(-10, 0, 10, 0, 0, 5, 0);
    add_row(-10, 0, 10, 0, 5, 10, 0);
    add_row(-10, 0, 10, 0, -5, 10, 1);
    // full range diagonals
    add_row(-32768, -32768, 32767, 32767, -32768, 32767, 0);
    add_row(-32768, -32768, 32767, 32767, 32767, -32768, 1);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 1);
    add_row(-32768, -32768, -32768, -32768, 32767, 32767, 1, 1, 0);
    // collinear overlap and collinear disjoint
    add_row(-10, 0, 10, 0, 20, 0, 0);
    add_row(-10, 0, 10, 0, 5, 0, 1);
    add_row(-10, 0, 10, 0, 20, 0, 0);
    add_row(-10, 0, 10, 0, 15, 0, 1);
    // segment swapped mid polygon
    add_row(-10, 0, 10, 0, 0, 5, 0);
    add_row(100, 100, 200, 100, 0, -5, 0);
    add_row(-10, 0, 10, 0, 1, 5, 1);
    // point query sitting on an edge
    add_row(2, 0, 2, 0, 0, 0, 0);
    add_row(2, 0, 2, 0, 4, 0, 0);
    add_row(2, 0, 2, 0, 2, 5, 1);

    first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
    hit_seen = 1'b0;
    in_run = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    while (random_sent < RANDOM_WORDS) begin
      scale = $urandom_range(0, 99);
      scale = (scale < 45) ? 0 : (scale < 70) ? 1 : (scale < 90) ? 2 : 3;
      n = $urandom_range(0, 99);
      n = (n < 15) ? 1 : (n < 85) ? $urandom_range(2, 6) : $urandom_range(7, 14);
      w.sx = pick_coord(scale);
      w.sy = pick_coord(scale);
      if ($urandom_range(0, 19) == 0) begin
        w.ex = w.sx;
        w.ey = w.sy;
      end else begin
        w.ex = pick_coord(scale);
        w.ey = pick_coord(scale);
      end
      w.typed = 1'b0;
      w.cut = 1'b0;
      for (int i = 0; i < n; i++) begin
        // occasional segment change inside a polygon
        if ($urandom_range(0, 19) == 0) begin
          w.sx = pick_coord(scale);
          w.ex = pick_coord(scale);
          w.sy = pick_coord(scale);
          w.ey = pick_coord(scale);
        end
        w.vx = pick_coord($urandom_range(0, 9) == 0 ? 2 : scale);
        w.vy = pick_coord($urandom_range(0, 9) == 0 ? 2 : scale);
        w.last = (i == n - 1);
        send_word(w);
        random_sent++;
      end
    end
    in_valid <= 1'b0;

    while (cut_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d vertex words (directed table plus random polygons)", words_sent);
    $display("checked %0d polygon results, %0d of them cut", results_seen, cuts_seen);
    if (errors == 0 && cut_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
